// ----- hdl/scnc_pkg.sv -----
// Package for the scan centroid block: widths, register indexes, reset values,
// sine polynomial coefficients and the sequencer state type.
// No dependencies; the two interfaces and scan_centroid import it.
package scnc_pkg;

    localparam int RNG_W     = 16;
    localparam int ANG_W     = 16;
    localparam int OUT_W     = 17;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LOW   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH  = CFG_IDX_W'(3);

    localparam logic [ANG_W-1:0] START_RST = 16'd0;
    localparam logic [ANG_W-1:0] STEP_RST  = 16'd64;
    localparam logic [RNG_W-1:0] LOW_RST   = 16'd0;
    localparam logic [RNG_W-1:0] HIGH_RST  = 16'hFFFF;

    localparam logic [14:0] QUARTER = 15'd16384;
    localparam logic [14:0] SIN_A   = 15'd25736;
    localparam logic [13:0] SIN_B   = 14'd10512;
    localparam logic [10:0] SIN_C   = 11'd1160;
    localparam logic [14:0] S_MAX   = 15'h7FFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG,
        ST_T2,
        ST_U,
        ST_V,
        ST_S,
        ST_MAG,
        ST_ADD,
        ST_FIN,
        ST_DIVX,
        ST_DIVY,
        ST_OUT
    } t_state;

endpackage

// ----- hdl/scnc_in_if.sv -----
// Input channel of the scan centroid block: one range sample per word.
// Depends on scnc_pkg.
interface scnc_in_if import scnc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RNG_W-1:0] range_mm;
    logic             last_sample;

    modport source(output valid, range_mm, last_sample, input ready);
    modport sink(input valid, range_mm, last_sample, output ready);
endinterface

// ----- hdl/scnc_out_if.sv -----
// Output channel of the scan centroid block: one centroid word per scan.
// Depends on scnc_pkg.
interface scnc_out_if import scnc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] centroid_x;
    logic signed [OUT_W-1:0] centroid_y;
    logic        [OUT_W-1:0] valid_points;

    modport source(output valid, centroid_x, centroid_y, valid_points, input ready);
    modport sink(input valid, centroid_x, centroid_y, valid_points, output ready);
endinterface

// ----- hdl/scnc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by scan_centroid for the two mean divisions.
module scnc_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        sh    = {r_rem, r_num[NUM_W-1]};
        diff  = sh - {1'b0, r_den};
        fits  = (sh >= {1'b0, r_den});
        n_rem = fits ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ----- hdl/scan_centroid.sv -----
// Scan centroid block: running mean of the Cartesian points of one polar scan.
// Depends on scnc_pkg, scnc_in_if, scnc_out_if and scnc_div.
//
// Usage: each word on i_in carries one range sample; the sample's angle is
// start_angle + index * angle_step. Samples strictly inside the configured
// range bounds are converted to x and y and summed. The word marked
// last_sample closes the scan, and one word with the mean x, mean y and the
// valid count then appears on o_out.
// Sequencing: a single 16x16 multiplier is shared under a sequencer. A sample
// outside the bounds only passes the angle state; a valid sample takes the angle
// product, then for cosine and sine four polynomial multiplies, one range
// multiply and one add. The last sample, when there are valid points, then runs
// two serial divisions of MAG_W bits each before the result word is loaded.
// i_in.ready is high only while the sequencer is idle.
// The result sits in an output register, so the next scan is accepted while
// a result waits; a stalled receiver only blocks the close of the next scan.
// Reset restores register defaults and clears the scan sums and counts.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write them only while idle; the block itself does not enforce it.
module scan_centroid import scnc_pkg::*; #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    scnc_in_if.sink              i_in,
    scnc_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [RNG_W-1:0]     i_cfg_data
);
    localparam int IDX_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = RNG_W + IDX_W + 1;
    localparam int MAG_W = SUM_W - 1;

    t_state r_state;
    t_state n_state;

    logic [ANG_W-1:0] r_start;
    logic [ANG_W-1:0] r_step;
    logic [RNG_W-1:0] r_low;
    logic [RNG_W-1:0] r_high;

    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sx;
    logic signed [SUM_W-1:0] r_sy;

    logic [RNG_W-1:0] r_rng;
    logic             r_last;
    logic             r_ok;
    logic [ANG_W-1:0] r_ang;
    logic             r_phase;
    logic [14:0]      r_t;
    logic             r_neg;
    logic [14:0]      r_t2;
    logic [13:0]      r_u;
    logic [14:0]      r_v;
    logic [14:0]      r_s;
    logic [RNG_W-1:0] r_mag;
    logic [OUT_W-1:0] r_qx;
    logic [OUT_W-1:0] r_qy;

    logic             r_ovalid;
    logic [OUT_W-1:0] r_ox;
    logic [OUT_W-1:0] r_oy;
    logic [OUT_W-1:0] r_ocnt;

    logic [15:0]      m_a;
    logic [15:0]      m_b;
    logic [31:0]      m_p;
    logic [17:0]      p_sh;
    logic [16:0]      s_full;

    logic [ANG_W-1:0] ang_new;
    logic [ANG_W-1:0] fold_ang;
    logic [14:0]      f_t;
    logic             f_neg;

    logic                    in_ok;
    logic                    idx_room;
    logic                    out_free;
    logic signed [SUM_W-1:0] mag_ext;
    logic signed [SUM_W-1:0] acc_in;
    logic signed [SUM_W-1:0] acc_out;
    logic [MAG_W-1:0]        sx_abs;
    logic [MAG_W-1:0]        sy_abs;

    logic             div_start;
    logic [MAG_W-1:0] div_num;
    logic             div_done;
    logic [MAG_W-1:0] div_quot;

    scnc_div #(
        .NUM_W(MAG_W),
        .DEN_W(IDX_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (r_cnt),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // Shared multiplier and its operand selection.
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            ST_ANG: begin
                m_a = r_step;
                m_b = 16'(r_idx);
            end
            ST_T2: begin
                m_a = 16'(r_t);
                m_b = 16'(r_t);
            end
            ST_U: begin
                m_a = 16'(r_t2);
                m_b = 16'(SIN_C);
            end
            ST_V: begin
                m_a = 16'(r_t2);
                m_b = 16'(r_u);
            end
            ST_S: begin
                m_a = 16'(r_t);
                m_b = 16'(r_v);
            end
            ST_MAG: begin
                m_a = r_rng;
                m_b = 16'(r_s);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p    = m_a * m_b;
    assign p_sh   = m_p[31:14];
    assign s_full = {p_sh[15:0], 1'b0};

    // The cosine is the sine a quarter turn ahead; fold the angle into one quadrant.
    assign ang_new  = r_start + m_p[15:0];
    assign fold_ang = (r_state == ST_ANG) ? ang_new + ANG_W'(QUARTER) : r_ang;
    assign f_t      = fold_ang[14] ? QUARTER - 15'(fold_ang[13:0]) : 15'(fold_ang[13:0]);
    assign f_neg    = fold_ang[15];

    assign in_ok    = (r_low < i_in.range_mm) && (i_in.range_mm < r_high);
    assign idx_room = (r_idx < IDX_W'(MAX_POINTS));
    assign out_free = !r_ovalid || o_out.ready;

    assign mag_ext = $signed({{(SUM_W - RNG_W){1'b0}}, r_mag});
    assign acc_in  = r_phase ? r_sy : r_sx;
    assign acc_out = r_neg ? acc_in - mag_ext : acc_in + mag_ext;
    assign sx_abs  = r_sx[SUM_W-1] ? MAG_W'(-r_sx) : MAG_W'(r_sx);
    assign sy_abs  = r_sy[SUM_W-1] ? MAG_W'(-r_sy) : MAG_W'(r_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_num   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_ANG;
                end
            end
            ST_ANG: begin
                if (idx_room && r_ok) begin
                    n_state = ST_T2;
                end else if (r_last) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_T2:  n_state = ST_U;
            ST_U:   n_state = ST_V;
            ST_V:   n_state = ST_S;
            ST_S:   n_state = ST_MAG;
            ST_MAG: n_state = ST_ADD;
            ST_ADD: begin
                if (!r_phase) begin
                    n_state = ST_T2;
                end else if (r_last) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end else begin
                    div_start = 1'b1;
                    div_num   = sx_abs;
                    n_state   = ST_DIVX;
                end
            end
            ST_DIVX: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_num   = sy_abs;
                    n_state   = ST_DIVY;
                end
            end
            ST_DIVY: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RST;
            r_step  <= STEP_RST;
            r_low   <= LOW_RST;
            r_high  <= HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START: r_start <= i_cfg_data;
                REG_STEP:  r_step  <= i_cfg_data;
                REG_LOW:   r_low   <= i_cfg_data;
                REG_HIGH:  r_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
        end else begin
            case (r_state)
                ST_ANG: begin
                    if (idx_room) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_ADD: begin
                    if (!r_phase) begin
                        r_sx <= acc_out;
                    end else begin
                        r_sy  <= acc_out;
                        r_cnt <= r_cnt + IDX_W'(1);
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_idx <= '0;
                        r_cnt <= '0;
                        r_sx  <= '0;
                        r_sy  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    r_rng  <= i_in.range_mm;
                    r_last <= i_in.last_sample;
                    r_ok   <= in_ok;
                end
            end
            ST_ANG: begin
                r_ang   <= ang_new;
                r_t     <= f_t;
                r_neg   <= f_neg;
                r_phase <= 1'b0;
            end
            ST_T2: r_t2 <= p_sh[14:0];
            ST_U:  r_u  <= 14'(18'(SIN_B) - p_sh);
            ST_V:  r_v  <= 15'(18'(SIN_A) - p_sh);
            ST_S:  r_s  <= (s_full > 17'(S_MAX)) ? S_MAX : s_full[14:0];
            ST_MAG: r_mag <= m_p[30:15];
            ST_ADD: begin
                if (!r_phase) begin
                    r_phase <= 1'b1;
                    r_t     <= f_t;
                    r_neg   <= f_neg;
                end
            end
            ST_FIN: begin
                r_qx <= '0;
                r_qy <= '0;
            end
            ST_DIVX: begin
                if (div_done) begin
                    r_qx <= r_sx[SUM_W-1] ? OUT_W'(-div_quot) : OUT_W'(div_quot);
                end
            end
            ST_DIVY: begin
                if (div_done) begin
                    r_qy <= r_sy[SUM_W-1] ? OUT_W'(-div_quot) : OUT_W'(div_quot);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_ox   <= r_qx;
                    r_oy   <= r_qy;
                    r_ocnt <= OUT_W'(r_cnt);
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.centroid_x   = $signed(r_ox);
    assign o_out.centroid_y   = $signed(r_oy);
    assign o_out.valid_points = r_ocnt;

`ifndef ASSERT_OFF
    a_cnt_le_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_idx)
        else $error("Valid count exceeds the sample index.");

    a_clear_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> (r_ovalid && r_idx == '0 && r_cnt == '0))
        else $error("Scan state was not cleared when the result word was loaded.");

    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVX && div_done) |=> (r_state == ST_DIVY))
        else $error("The y division did not follow the x division.");
`endif

endmodule
